// File: rtl/sorted_priority_task_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted_priority_task_queue_assert.svh
// Assertion macros used by the sorted priority task queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_TASK_QUEUE_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define SPQ_ASSERT_SAME(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// property that must hold in the cycle after its trigger
`define SPQ_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Request and status codes and default sizes of the sorted priority task queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	// default sizes
	localparam int DEPTH_DEF     = 16;
	localparam int ID_BITS_DEF   = 16;
	localparam int PRIO_BITS_DEF = 8;

	// request codes
	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_RM_HIGH = 2'd1,
		REQ_RM_ID   = 2'd2,
		REQ_LIST    = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

// File: rtl/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store of the task queue: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module spq_mem #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int WIDTH = spq_pkg::ID_BITS_DEF + spq_pkg::PRIO_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Bounded task list kept in priority order, with add, remove-highest,
// remove-by-id and list requests.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; in_stall is low only while no request is
// in work, and a new request may be taken while the previous result still
// waits at the output register. Entries live in a single-port-read,
// single-port-write memory, and every request that touches stored entries walks
// them one per cycle through a read / write-back pipe, a list only while the
// output is not stalled. An add walks from the tail down to its place, moving
// each lower-priority entry up one slot; remove by id walks the whole store,
// closing the gap behind the dropped entry, and remove-highest walks all but
// the head; a list gives one transaction per entry. Requests that need no walk
// (full, empty, first add, removal from a single-entry store) go straight to
// their result. The next request can be taken in the cycle after the last
// result transaction is loaded; output stalls hold a request in work longer.
// Equal priorities keep arrival order, and remove by id drops the first
// matching entry in stored order.
`include "sorted_priority_task_queue_assert.svh"

module sorted_priority_task_queue #(
	parameter int DEPTH     = spq_pkg::DEPTH_DEF,
	parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [ID_BITS-1:0]   task_id,
	input  logic [PRIO_BITS-1:0] priority_req,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [ID_BITS-1:0]   out_task_id,
	output logic [PRIO_BITS-1:0] out_priority,
	output logic                 last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = ID_BITS + PRIO_BITS;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_INS, S_RESP} state_t;

	state_t                 state_q;
	spq_pkg::req_t          op_q;
	spq_pkg::status_t       res_status_q;
	logic [ID_BITS-1:0]     id_q;
	logic [PRIO_BITS-1:0]   pr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [CNT_W-1:0]       rem_q;
	logic                   found_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   last_s1;

	logic                   out_vld_q;
	spq_pkg::status_t       out_st_q;
	logic [ID_BITS-1:0]     out_id_q;
	logic [PRIO_BITS-1:0]   out_pr_q;
	logic                   out_last_q;

	logic                   in_fire;
	logic                   out_free;
	logic                   s1_take;
	logic                   s1_fire;
	logic                   add_place;
	logic                   rd_en;
	logic                   hit;
	logic [ENT_W-1:0]       rdata_s1;
	logic [ID_BITS-1:0]     rd_id;
	logic [PRIO_BITS-1:0]   rd_pr;

	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [ENT_W-1:0]       wdata;

	logic                   out_load;
	spq_pkg::status_t       out_st_d;
	logic [ID_BITS-1:0]     out_id_d;
	logic [PRIO_BITS-1:0]   out_pr_d;
	logic                   out_last_d;

	// handshake and walk pacing
	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_vld_q || !out_stall;
	assign s1_take  = (op_q != spq_pkg::REQ_LIST) || out_free;
	assign s1_fire  = (state_q == S_WALK) && vld_s1 && s1_take;
	assign rd_en    = (state_q == S_WALK) && (rem_q != '0) && (!vld_s1 || s1_take);

	// fields of the entry read back
	assign rd_id = rdata_s1[ENT_W-1:PRIO_BITS];
	assign rd_pr = rdata_s1[PRIO_BITS-1:0];
	assign hit   = (op_q == spq_pkg::REQ_RM_ID) && (rd_id == id_q);

	// add has found its place, any read ahead is dropped
	assign add_place = s1_fire && (op_q == spq_pkg::REQ_ADD) && (rd_pr >= pr_q);

	spq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (rdata_s1)
	);

	// write-back: shift entries up on add, down on remove, place new task
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = {id_q, pr_q};
		if (in_fire && (spq_pkg::req_t'(req_type) == spq_pkg::REQ_ADD) && (cnt_q == '0)) begin
			we    = 1'b1;
			wdata = {task_id, priority_req};
		end else if (state_q == S_INS) begin
			we = 1'b1;
		end else if (s1_fire) begin
			case (op_q) inside
				spq_pkg::REQ_ADD: begin
					we    = 1'b1;
					waddr = idx_s1 + 1'b1;
					if (rd_pr < pr_q) begin
						wdata = rdata_s1;
					end
				end
				spq_pkg::REQ_RM_HIGH, spq_pkg::REQ_RM_ID: begin
					if (found_q) begin
						we    = 1'b1;
						waddr = idx_s1 - 1'b1;
						wdata = rdata_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// next output transaction
	always_comb begin
		out_load   = 1'b0;
		out_st_d   = res_status_q;
		out_id_d   = '0;
		out_pr_d   = '0;
		out_last_d = 1'b1;
		if ((state_q == S_RESP) && out_free) begin
			out_load = 1'b1;
		end else if (s1_fire && (op_q == spq_pkg::REQ_LIST)) begin
			out_load   = 1'b1;
			out_st_d   = spq_pkg::ST_OK;
			out_id_d   = rd_id;
			out_pr_d   = rd_pr;
			out_last_d = last_s1;
		end
	end

	// request sequencer, read pipe and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			found_q   <= 1'b0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// output register
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_st_q   <= out_st_d;
				out_id_q   <= out_id_d;
				out_pr_q   <= out_pr_d;
				out_last_q <= out_last_d;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end

			// read issue and stage one
			if (rd_en) begin
				rd_idx_q <= (op_q == spq_pkg::REQ_ADD) ? rd_idx_q - 1'b1 : rd_idx_q + 1'b1;
				rem_q    <= rem_q - 1'b1;
				idx_s1   <= rd_idx_q;
				last_s1  <= (rem_q == CNT_W'(1));
			end
			if (rd_en && !add_place) begin
				vld_s1 <= 1'b1;
			end else if (s1_fire) begin
				vld_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q    <= spq_pkg::req_t'(req_type);
						id_q    <= task_id;
						pr_q    <= priority_req;
						found_q <= 1'b0;
						unique case (spq_pkg::req_t'(req_type)) inside
							spq_pkg::REQ_ADD: begin
								if (cnt_q == CNT_W'(DEPTH)) begin
									res_status_q <= spq_pkg::ST_FULL;
									state_q      <= S_RESP;
								end else if (cnt_q == '0) begin
									cnt_q        <= CNT_W'(1);
									res_status_q <= spq_pkg::ST_OK;
									state_q      <= S_RESP;
								end else begin
									rd_idx_q <= IDX_W'(cnt_q - 1'b1);
									rem_q    <= cnt_q;
									state_q  <= S_WALK;
								end
							end
							spq_pkg::REQ_RM_HIGH: begin
								if (cnt_q == '0) begin
									res_status_q <= spq_pkg::ST_EMPTY;
									state_q      <= S_RESP;
								end else if (cnt_q == CNT_W'(1)) begin
									cnt_q        <= '0;
									res_status_q <= spq_pkg::ST_OK;
									state_q      <= S_RESP;
								end else begin
									// head is dropped: walk from slot one, moving down
									rd_idx_q <= IDX_W'(1);
									rem_q    <= cnt_q - 1'b1;
									found_q  <= 1'b1;
									state_q  <= S_WALK;
								end
							end
							spq_pkg::REQ_RM_ID, spq_pkg::REQ_LIST: begin
								if (cnt_q == '0) begin
									res_status_q <= spq_pkg::ST_EMPTY;
									state_q      <= S_RESP;
								end else begin
									rd_idx_q <= '0;
									rem_q    <= cnt_q;
									state_q  <= S_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (s1_fire) begin
						case (op_q) inside
							spq_pkg::REQ_ADD: begin
								if (rd_pr < pr_q) begin
									if (last_s1) begin
										state_q <= S_INS;
									end
								end else begin
									// new task placed behind this entry
									cnt_q        <= cnt_q + 1'b1;
									res_status_q <= spq_pkg::ST_OK;
									state_q      <= S_RESP;
								end
							end
							spq_pkg::REQ_RM_HIGH, spq_pkg::REQ_RM_ID: begin
								if (!found_q && hit) begin
									found_q <= 1'b1;
								end
								if (last_s1) begin
									if (found_q || hit) begin
										cnt_q        <= cnt_q - 1'b1;
										res_status_q <= spq_pkg::ST_OK;
									end else begin
										res_status_q <= spq_pkg::ST_NOT_FOUND;
									end
									state_q <= S_RESP;
								end
							end
							default: begin
								if (last_s1) begin
									state_q <= S_IDLE;
								end
							end
						endcase
					end
				end
				S_INS: begin
					cnt_q        <= cnt_q + 1'b1;
					res_status_q <= spq_pkg::ST_OK;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign out_valid    = out_vld_q;
	assign status       = out_st_q;
	assign out_task_id  = out_id_q;
	assign out_priority = out_pr_q;
	assign last         = out_last_q;

	// checks
	`SPQ_ASSERT_SAME(a_idle_pipe_empty, !in_stall, !vld_s1, "read pipe busy while taking a request")
	`SPQ_ASSERT_SAME(a_full_status, out_load && (out_st_d == spq_pkg::ST_FULL), cnt_q == CNT_W'(DEPTH), "full status with free slots")
	`SPQ_ASSERT_NEXT(a_list_end, out_load && (op_q == spq_pkg::REQ_LIST) && (state_q == S_WALK) && out_last_d, state_q == S_IDLE, "list did not end on its last entry")
	`SPQ_ASSERT_NEXT(a_count_step, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q + 1'b1 == $past(cnt_q)), "entry count moved by more than one")

endmodule
